### rtl/tangent_circle_placement_assert.svh
// Assertion macros for the tangent circle placement block.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef TANGENT_CIRCLE_PLACEMENT_ASSERT_SVH
`define TANGENT_CIRCLE_PLACEMENT_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define TCP_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("tangent circle placement: implication check failed");

// The condition must never be seen.
`define TCP_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("tangent circle placement: forbidden condition seen");

`else

`define TCP_ASSERT_IMP(name, pre, post)
`define TCP_ASSERT_NEVER(name, cond)

`endif

`endif

### rtl/tcp_pkg.sv
package tcp_pkg;

  // Solution count codes.
  localparam int COUNT_BITS = 2;
  typedef logic [COUNT_BITS-1:0] count_t;
  localparam count_t SOL_NONE = 2'd0;
  localparam count_t SOL_PAIR = 2'd2;

endpackage

### rtl/tcp_if.sv
// Query channel: two circles, the radius to place and the inside flag.
interface tcp_in_if import tcp_pkg::*; #(
  parameter int WORD_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] first_centre_x;
  logic signed [WORD_BITS-1:0] first_centre_y;
  logic        [WORD_BITS-2:0] first_radius;
  logic signed [WORD_BITS-1:0] second_centre_x;
  logic signed [WORD_BITS-1:0] second_centre_y;
  logic        [WORD_BITS-2:0] second_radius;
  logic        [WORD_BITS-2:0] new_radius;
  logic                        inside_second;

  modport source (
    output valid, first_centre_x, first_centre_y, first_radius,
           second_centre_x, second_centre_y, second_radius, new_radius, inside_second,
    input  ready
  );
  modport sink (
    input  valid, first_centre_x, first_centre_y, first_radius,
           second_centre_x, second_centre_y, second_radius, new_radius, inside_second,
    output ready
  );
endinterface

// Result channel: solution count and both candidate centres.
interface tcp_out_if import tcp_pkg::*; #(
  parameter int WORD_BITS = 32
);
  logic                        valid;
  logic                        ready;
  count_t                      solution_count;
  logic signed [WORD_BITS-1:0] sol_one_x;
  logic signed [WORD_BITS-1:0] sol_one_y;
  logic signed [WORD_BITS-1:0] sol_two_x;
  logic signed [WORD_BITS-1:0] sol_two_y;

  modport source (
    output valid, solution_count, sol_one_x, sol_one_y, sol_two_x, sol_two_y,
    input  ready
  );
  modport sink (
    input  valid, solution_count, sol_one_x, sol_one_y, sol_two_x, sol_two_y,
    output ready
  );
endinterface

### rtl/tcp_div.sv
// Pipelined fixed-point divider: one quotient bit per stage, rounded to
// nearest with halves away from zero, saturated to the word range.
// A zero divisor gives zero. Side data travels with each item.
module tcp_div #(
  parameter int WORD_BITS     = 32,
  parameter int FRACTION_BITS = 16,
  parameter int SIDE_BITS     = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        ce,
  input  logic                        in_vld,
  input  logic signed [WORD_BITS-1:0] num,
  input  logic signed [WORD_BITS-1:0] den,
  input  logic        [SIDE_BITS-1:0] in_side,
  output logic                        out_vld,
  output logic signed [WORD_BITS-1:0] quo,
  output logic        [SIDE_BITS-1:0] out_side
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRACTION_BITS;
  localparam int NB = W + F + 2;
  localparam logic [NB-1:0] POS_LIM = {{(NB-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [NB-1:0] NEG_LIM = POS_LIM + 1'b1;
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  function automatic logic [W-1:0] qmag(input logic signed [W-1:0] v);
    logic [W-1:0] u;
    u = v;
    return v[W-1] ? (~u + 1'b1) : u;
  endfunction

  function automatic logic signed [W-1:0] from_mag(input logic neg, input logic [NB-1:0] m);
    logic [W-1:0] lo;
    lo = m[W-1:0];
    if (neg) begin
      if (m > NEG_LIM) return VMIN;
      return $signed(~lo + 1'b1);
    end
    if (m > POS_LIM) return VMAX;
    return $signed(lo);
  endfunction

  logic [NB-1:0]        num_r  [0:NB];
  logic [W:0]           rem_r  [0:NB];
  logic [NB-1:0]        quo_r  [0:NB];
  logic [W:0]           den_r  [0:NB];
  logic                 neg_r  [0:NB];
  logic                 dz_r   [0:NB];
  logic                 vld_r  [0:NB];
  logic [SIDE_BITS-1:0] side_r [0:NB];

  logic [NB-1:0] num_ext;
  logic                        out_vld_r;
  logic signed [W-1:0]         quo_r_out;
  logic [SIDE_BITS-1:0]        out_side_r;

  // Numerator scaled by 2^(F+1) plus the divisor, so the floor divide rounds.
  assign num_ext = ({{(F+2){1'b0}}, qmag(num)} << (F + 1)) + {{(F+2){1'b0}}, qmag(den)};

  // Entry stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (ce) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      num_r[0]  <= num_ext;
      rem_r[0]  <= '0;
      quo_r[0]  <= '0;
      den_r[0]  <= {qmag(den), 1'b0};
      neg_r[0]  <= num[W-1] ^ den[W-1];
      dz_r[0]   <= (den == '0);
      side_r[0] <= in_side;
    end
  end

  // One restoring step per stage.
  for (genvar k = 1; k <= NB; k++) begin : g_step
    logic [W+1:0] trial;
    logic [W+1:0] diff;
    logic         ge;

    assign trial = {rem_r[k-1], num_r[k-1][NB-k]};
    assign diff  = trial - {1'b0, den_r[k-1]};
    assign ge    = (trial >= {1'b0, den_r[k-1]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (ce) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        num_r[k]  <= num_r[k-1];
        rem_r[k]  <= ge ? diff[W:0] : trial[W:0];
        quo_r[k]  <= {quo_r[k-1][NB-2:0], ge};
        den_r[k]  <= den_r[k-1];
        neg_r[k]  <= neg_r[k-1];
        dz_r[k]   <= dz_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // Sign, saturation and zero-divisor handling.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (ce) begin
      out_vld_r <= vld_r[NB];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      quo_r_out  <= dz_r[NB] ? '0 : from_mag(neg_r[NB], quo_r[NB]);
      out_side_r <= side_r[NB];
    end
  end

  assign out_vld  = out_vld_r;
  assign quo      = quo_r_out;
  assign out_side = out_side_r;

endmodule

### rtl/tangent_circle_placement.sv
// Tangent circle placement. Each query gives two circles, a radius and an
// inside flag; the block returns the two centres at which a circle of that
// radius touches both, or a count of zero with zeroed centres when the
// centres coincide, the discriminant is negative or the quadratic term
// vanishes. All values are signed fixed point, WORD_BITS wide with
// FRACTION_BITS fraction bits, and every step saturates. The pipeline takes
// one query per cycle and holds no state between queries. Besides its
// fixed stages, each query passes a bit-per-stage divider for the radical
// line point, a parallel pair of them for the two roots and a bit-per-stage
// square root. When the result side stalls, the whole pipeline holds.
`include "tangent_circle_placement_assert.svh"

module tangent_circle_placement import tcp_pkg::*; #(
  parameter int WORD_BITS     = 32,
  parameter int FRACTION_BITS = 16
) (
  input logic      clk,
  input logic      rst_n,
  tcp_in_if.sink   in_ch,
  tcp_out_if.source out_ch
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRACTION_BITS;
  localparam int MW = 2 * W + F + 2;
  localparam int RB = (W + F) / 2;
  localparam int XB = 2 * RB;
  localparam logic [MW-1:0] POS_LIM = {{(MW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [MW-1:0] NEG_LIM = POS_LIM + 1'b1;
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W+2:0] XMAX = {4'b0000, {(W-1){1'b1}}};
  localparam logic signed [W+2:0] XMIN = {4'b1111, {(W-1){1'b0}}};
  localparam logic [2*W-1:0] HALF = (2 * W)'(1) << (F - 1);

  // ---------------------------------------------------------------------
  // Fixed-point helpers.

  function automatic logic signed [W+2:0] ext(input logic signed [W-1:0] a);
    return {{3{a[W-1]}}, a};
  endfunction

  function automatic logic signed [W-1:0] sat_w(input logic signed [W+2:0] v);
    if (v > XMAX) return VMAX;
    if (v < XMIN) return VMIN;
    return v[W-1:0];
  endfunction

  function automatic logic [W-1:0] qmag(input logic signed [W-1:0] v);
    logic [W-1:0] u;
    u = v;
    return v[W-1] ? (~u + 1'b1) : u;
  endfunction

  function automatic logic signed [W-1:0] from_mag(input logic neg, input logic [MW-1:0] m);
    logic [W-1:0] lo;
    lo = m[W-1:0];
    if (neg) begin
      if (m > NEG_LIM) return VMIN;
      return $signed(~lo + 1'b1);
    end
    if (m > POS_LIM) return VMAX;
    return $signed(lo);
  endfunction

  function automatic logic signed [2*W-1:0] mul(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
    logic [2*W-1:0] ea;
    logic [2*W-1:0] eb;
    ea = {{W{a[W-1]}}, a};
    eb = {{W{b[W-1]}}, b};
    return $signed(ea * eb);
  endfunction

  // Round a raw product to nearest, halves away from zero, and saturate.
  function automatic logic signed [W-1:0] q_round(input logic signed [2*W-1:0] p);
    logic [2*W-1:0] u;
    logic [2*W-1:0] m;
    logic [2*W-1:0] r;
    u = p;
    m = p[2*W-1] ? (~u + 1'b1) : u;
    r = (m + HALF) >> F;
    return from_mag(p[2*W-1], {{(MW-2*W){1'b0}}, r});
  endfunction

  function automatic logic signed [W-1:0] q_half(input logic signed [W-1:0] v);
    logic [W:0] m;
    m = ({1'b0, qmag(v)} + 1'b1) >> 1;
    return from_mag(v[W-1], {{(MW-W-1){1'b0}}, m});
  endfunction

  // ---------------------------------------------------------------------
  // Side data carried through the dividers and the square root.

  typedef struct packed {
    logic signed [W-1:0] c1x;
    logic signed [W-1:0] c1y;
    logic signed [W-1:0] aox;
    logic signed [W-1:0] aoy;
    logic signed [W-1:0] m13;
    logic signed [W-1:0] qa;
    logic                sel;
    logic                zero;
  } d1_side_t;

  typedef struct packed {
    logic signed [W-1:0] ox;
    logic signed [W-1:0] oy;
    logic signed [W-1:0] aox;
    logic signed [W-1:0] aoy;
    logic signed [W-1:0] twoa;
    logic signed [W-1:0] nqb;
    logic                ok;
  } sq_side_t;

  typedef struct packed {
    logic signed [W-1:0] ox;
    logic signed [W-1:0] oy;
    logic signed [W-1:0] aox;
    logic signed [W-1:0] aoy;
    logic                ok;
  } d2_side_t;

  localparam int D1_SIDE_BITS = $bits(d1_side_t);
  localparam int D2_SIDE_BITS = $bits(d2_side_t);

  // Global advance: the pipeline moves whenever the output register can take an item.
  logic ce;
  logic out_vld_r;

  assign ce          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = ce;

  // ---------------------------------------------------------------------
  // Stage 0: input register.
  logic                s0_vld_r;
  logic signed [W-1:0] s0_c1x_r, s0_c1y_r, s0_c2x_r, s0_c2y_r;
  logic        [W-2:0] s0_r1_r, s0_r2_r, s0_r3_r;
  logic                s0_in_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (ce) begin
      s0_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s0_c1x_r <= in_ch.first_centre_x;
      s0_c1y_r <= in_ch.first_centre_y;
      s0_r1_r  <= in_ch.first_radius;
      s0_c2x_r <= in_ch.second_centre_x;
      s0_c2y_r <= in_ch.second_centre_y;
      s0_r2_r  <= in_ch.second_radius;
      s0_r3_r  <= in_ch.new_radius;
      s0_in_r  <= in_ch.inside_second;
    end
  end

  // Stage 1: summed radii and the centre difference.
  logic                s1_vld_r;
  logic signed [W-1:0] s1_r13_r, s1_r23_r, s1_ax_r, s1_ay_r;
  logic signed [W-1:0] s1_c1x_r, s1_c1y_r, s1_c2x_r, s1_c2y_r;
  logic signed [W+2:0] s1_sr3;

  assign s1_sr3 = s0_in_r ? -ext({1'b0, s0_r3_r}) : ext({1'b0, s0_r3_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (ce) begin
      s1_vld_r <= s0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_r13_r <= sat_w(ext({1'b0, s0_r1_r}) + ext({1'b0, s0_r3_r}));
      s1_r23_r <= sat_w(ext({1'b0, s0_r2_r}) + s1_sr3);
      s1_ax_r  <= sat_w(ext(s0_c2x_r) - ext(s0_c1x_r));
      s1_ay_r  <= sat_w(ext(s0_c2y_r) - ext(s0_c1y_r));
      s1_c1x_r <= s0_c1x_r;
      s1_c1y_r <= s0_c1y_r;
      s1_c2x_r <= s0_c2x_r;
      s1_c2y_r <= s0_c2y_r;
    end
  end

  // Stage 2: squares for the radical line, the normal and the divide axis.
  logic                  s2_vld_r;
  logic signed [2*W-1:0] s2_p13_r, s2_p23_r, s2_pc1x_r, s2_pc1y_r, s2_pc2x_r, s2_pc2y_r;
  logic signed [W-1:0]   s2_aox_r, s2_aoy_r, s2_den_r, s2_c1x_r, s2_c1y_r;
  logic                  s2_sel_r, s2_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (ce) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s2_p13_r  <= mul(s1_r13_r, s1_r13_r);
      s2_p23_r  <= mul(s1_r23_r, s1_r23_r);
      s2_pc1x_r <= mul(s1_c1x_r, s1_c1x_r);
      s2_pc1y_r <= mul(s1_c1y_r, s1_c1y_r);
      s2_pc2x_r <= mul(s1_c2x_r, s1_c2x_r);
      s2_pc2y_r <= mul(s1_c2y_r, s1_c2y_r);
      s2_aox_r  <= s1_ay_r;
      s2_aoy_r  <= sat_w(-ext(s1_ax_r));
      s2_sel_r  <= qmag(s1_ax_r) > qmag(s1_ay_r);
      s2_den_r  <= (qmag(s1_ax_r) > qmag(s1_ay_r)) ? s1_ax_r : s1_ay_r;
      s2_zero_r <= (s1_ax_r == '0) && (s1_ay_r == '0);
      s2_c1x_r  <= s1_c1x_r;
      s2_c1y_r  <= s1_c1y_r;
    end
  end

  // Stage 3: rounded squares, squared lengths and normal squares.
  logic                  s3_vld_r;
  logic signed [W-1:0]   s3_m13_r, s3_b0_r, s3_l1_r, s3_l2_r;
  logic signed [2*W-1:0] s3_pa_r, s3_pb_r;
  logic signed [W-1:0]   s3_aox_r, s3_aoy_r, s3_den_r, s3_c1x_r, s3_c1y_r;
  logic                  s3_sel_r, s3_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (ce) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s3_m13_r  <= q_round(s2_p13_r);
      s3_b0_r   <= sat_w(ext(q_round(s2_p13_r)) - ext(q_round(s2_p23_r)));
      s3_l1_r   <= sat_w(ext(q_round(s2_pc1x_r)) + ext(q_round(s2_pc1y_r)));
      s3_l2_r   <= sat_w(ext(q_round(s2_pc2x_r)) + ext(q_round(s2_pc2y_r)));
      s3_pa_r   <= mul(s2_aox_r, s2_aox_r);
      s3_pb_r   <= mul(s2_aoy_r, s2_aoy_r);
      s3_aox_r  <= s2_aox_r;
      s3_aoy_r  <= s2_aoy_r;
      s3_den_r  <= s2_den_r;
      s3_c1x_r  <= s2_c1x_r;
      s3_c1y_r  <= s2_c1y_r;
      s3_sel_r  <= s2_sel_r;
      s3_zero_r <= s2_zero_r;
    end
  end

  // Stage 4: radical line offset, second term, and the quadratic term.
  logic                s4_vld_r;
  logic signed [W-1:0] s4_b1_r, s4_l2_r, s4_qa_r, s4_m13_r;
  logic signed [W-1:0] s4_aox_r, s4_aoy_r, s4_den_r, s4_c1x_r, s4_c1y_r;
  logic                s4_sel_r, s4_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (ce) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s4_b1_r   <= sat_w(ext(s3_b0_r) - ext(s3_l1_r));
      s4_l2_r   <= s3_l2_r;
      s4_qa_r   <= sat_w(ext(q_round(s3_pa_r)) + ext(q_round(s3_pb_r)));
      s4_m13_r  <= s3_m13_r;
      s4_aox_r  <= s3_aox_r;
      s4_aoy_r  <= s3_aoy_r;
      s4_den_r  <= s3_den_r;
      s4_c1x_r  <= s3_c1x_r;
      s4_c1y_r  <= s3_c1y_r;
      s4_sel_r  <= s3_sel_r;
      s4_zero_r <= s3_zero_r;
    end
  end

  // Stage 5: final radical line offset, halved.
  logic                s5_vld_r;
  logic signed [W-1:0] s5_b_r, s5_qa_r, s5_m13_r;
  logic signed [W-1:0] s5_aox_r, s5_aoy_r, s5_den_r, s5_c1x_r, s5_c1y_r;
  logic                s5_sel_r, s5_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (ce) begin
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s5_b_r    <= q_half(sat_w(ext(s4_b1_r) + ext(s4_l2_r)));
      s5_qa_r   <= s4_qa_r;
      s5_m13_r  <= s4_m13_r;
      s5_aox_r  <= s4_aox_r;
      s5_aoy_r  <= s4_aoy_r;
      s5_den_r  <= s4_den_r;
      s5_c1x_r  <= s4_c1x_r;
      s5_c1y_r  <= s4_c1y_r;
      s5_sel_r  <= s4_sel_r;
      s5_zero_r <= s4_zero_r;
    end
  end

  // Point on the radical line: divide by the larger difference component.
  d1_side_t            d1_side_in, d1_side_out;
  logic [D1_SIDE_BITS-1:0] d1_side_vec;
  logic                d1_vld;
  logic signed [W-1:0] d1_quo;

  assign d1_side_in = '{c1x: s5_c1x_r, c1y: s5_c1y_r, aox: s5_aox_r, aoy: s5_aoy_r,
                        m13: s5_m13_r, qa: s5_qa_r, sel: s5_sel_r, zero: s5_zero_r};
  assign d1_side_out = d1_side_t'(d1_side_vec);

  tcp_div #(
    .WORD_BITS     (W),
    .FRACTION_BITS (F),
    .SIDE_BITS     (D1_SIDE_BITS)
  ) u_div_line (
    .clk      (clk),
    .rst_n    (rst_n),
    .ce       (ce),
    .in_vld   (s5_vld_r),
    .num      (s5_b_r),
    .den      (s5_den_r),
    .in_side  (d1_side_in),
    .out_vld  (d1_vld),
    .quo      (d1_quo),
    .out_side (d1_side_vec)
  );

  // Stage 6: line point and its offset from the first centre.
  logic                s6_vld_r;
  logic signed [W-1:0] s6_ox_r, s6_oy_r, s6_px_r, s6_py_r;
  logic signed [W-1:0] s6_aox_r, s6_aoy_r, s6_m13_r, s6_qa_r;
  logic                s6_zero_r;
  logic signed [W-1:0] s6_ox, s6_oy;

  assign s6_ox = d1_side_out.sel ? d1_quo : '0;
  assign s6_oy = d1_side_out.sel ? '0 : d1_quo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else if (ce) begin
      s6_vld_r <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s6_ox_r   <= s6_ox;
      s6_oy_r   <= s6_oy;
      s6_px_r   <= sat_w(ext(s6_ox) - ext(d1_side_out.c1x));
      s6_py_r   <= sat_w(ext(s6_oy) - ext(d1_side_out.c1y));
      s6_aox_r  <= d1_side_out.aox;
      s6_aoy_r  <= d1_side_out.aoy;
      s6_m13_r  <= d1_side_out.m13;
      s6_qa_r   <= d1_side_out.qa;
      s6_zero_r <= d1_side_out.zero;
    end
  end

  // Stage 7: products for the linear and constant quadratic terms.
  logic                  s7_vld_r;
  logic signed [2*W-1:0] s7_ppa_r, s7_ppb_r, s7_ppx_r, s7_ppy_r;
  logic signed [W-1:0]   s7_ox_r, s7_oy_r, s7_aox_r, s7_aoy_r, s7_m13_r, s7_qa_r;
  logic                  s7_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_vld_r <= 1'b0;
    end else if (ce) begin
      s7_vld_r <= s6_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s7_ppa_r  <= mul(s6_px_r, s6_aox_r);
      s7_ppb_r  <= mul(s6_py_r, s6_aoy_r);
      s7_ppx_r  <= mul(s6_px_r, s6_px_r);
      s7_ppy_r  <= mul(s6_py_r, s6_py_r);
      s7_ox_r   <= s6_ox_r;
      s7_oy_r   <= s6_oy_r;
      s7_aox_r  <= s6_aox_r;
      s7_aoy_r  <= s6_aoy_r;
      s7_m13_r  <= s6_m13_r;
      s7_qa_r   <= s6_qa_r;
      s7_zero_r <= s6_zero_r;
    end
  end

  // Stage 8: dot product and squared offset length.
  logic                s8_vld_r;
  logic signed [W-1:0] s8_s_r, s8_lp_r;
  logic signed [W-1:0] s8_ox_r, s8_oy_r, s8_aox_r, s8_aoy_r, s8_m13_r, s8_qa_r;
  logic                s8_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_vld_r <= 1'b0;
    end else if (ce) begin
      s8_vld_r <= s7_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s8_s_r    <= sat_w(ext(q_round(s7_ppa_r)) + ext(q_round(s7_ppb_r)));
      s8_lp_r   <= sat_w(ext(q_round(s7_ppx_r)) + ext(q_round(s7_ppy_r)));
      s8_ox_r   <= s7_ox_r;
      s8_oy_r   <= s7_oy_r;
      s8_aox_r  <= s7_aox_r;
      s8_aoy_r  <= s7_aoy_r;
      s8_m13_r  <= s7_m13_r;
      s8_qa_r   <= s7_qa_r;
      s8_zero_r <= s7_zero_r;
    end
  end

  // Stage 9: linear and constant coefficients of the quadratic.
  logic                s9_vld_r;
  logic signed [W-1:0] s9_qb_r, s9_qc_r;
  logic signed [W-1:0] s9_ox_r, s9_oy_r, s9_aox_r, s9_aoy_r, s9_qa_r;
  logic                s9_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s9_vld_r <= 1'b0;
    end else if (ce) begin
      s9_vld_r <= s8_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s9_qb_r   <= sat_w(ext(s8_s_r) <<< 1);
      s9_qc_r   <= sat_w(ext(s8_lp_r) - ext(s8_m13_r));
      s9_ox_r   <= s8_ox_r;
      s9_oy_r   <= s8_oy_r;
      s9_aox_r  <= s8_aox_r;
      s9_aoy_r  <= s8_aoy_r;
      s9_qa_r   <= s8_qa_r;
      s9_zero_r <= s8_zero_r;
    end
  end

  // Stage 10: discriminant products.
  logic                  s10_vld_r;
  logic signed [2*W-1:0] s10_pbb_r, s10_pac_r;
  logic signed [W-1:0]   s10_qb_r, s10_qa_r, s10_ox_r, s10_oy_r, s10_aox_r, s10_aoy_r;
  logic                  s10_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s10_vld_r <= 1'b0;
    end else if (ce) begin
      s10_vld_r <= s9_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s10_pbb_r  <= mul(s9_qb_r, s9_qb_r);
      s10_pac_r  <= mul(s9_qa_r, s9_qc_r);
      s10_qb_r   <= s9_qb_r;
      s10_qa_r   <= s9_qa_r;
      s10_ox_r   <= s9_ox_r;
      s10_oy_r   <= s9_oy_r;
      s10_aox_r  <= s9_aox_r;
      s10_aoy_r  <= s9_aoy_r;
      s10_zero_r <= s9_zero_r;
    end
  end

  // Stage 11: rounded discriminant terms.
  logic                s11_vld_r;
  logic signed [W-1:0] s11_u_r, s11_v_r;
  logic signed [W-1:0] s11_qb_r, s11_qa_r, s11_ox_r, s11_oy_r, s11_aox_r, s11_aoy_r;
  logic                s11_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s11_vld_r <= 1'b0;
    end else if (ce) begin
      s11_vld_r <= s10_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s11_u_r    <= q_round(s10_pbb_r);
      s11_v_r    <= sat_w(ext(q_round(s10_pac_r)) <<< 2);
      s11_qb_r   <= s10_qb_r;
      s11_qa_r   <= s10_qa_r;
      s11_ox_r   <= s10_ox_r;
      s11_oy_r   <= s10_oy_r;
      s11_aox_r  <= s10_aox_r;
      s11_aoy_r  <= s10_aoy_r;
      s11_zero_r <= s10_zero_r;
    end
  end

  // Stage 12: discriminant, solvability and the square root operand.
  logic signed [W-1:0] s12_delta;
  logic                s12_ok;
  logic [XB-1:0]       s12_x;

  assign s12_delta = sat_w(ext(s11_u_r) - ext(s11_v_r));
  assign s12_ok    = !s11_zero_r && !s12_delta[W-1] && (s11_qa_r != '0);
  assign s12_x     = XB'({s12_delta[W-2:0], {F{1'b0}}});

  logic          sq_vld_r  [0:RB];
  logic [XB-1:0] sq_x_r    [0:RB];
  logic [RB+1:0] sq_rem_r  [0:RB];
  logic [RB-1:0] sq_root_r [0:RB];
  sq_side_t      sq_side_r [0:RB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r[0] <= 1'b0;
    end else if (ce) begin
      sq_vld_r[0] <= s11_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sq_x_r[0]    <= s12_ok ? s12_x : '0;
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_side_r[0] <= '{ox: s11_ox_r, oy: s11_oy_r, aox: s11_aox_r, aoy: s11_aoy_r,
                         twoa: sat_w(ext(s11_qa_r) <<< 1), nqb: sat_w(-ext(s11_qb_r)),
                         ok: s12_ok};
    end
  end

  // Square root, one result bit per stage.
  for (genvar k = 1; k <= RB; k++) begin : g_sqrt
    logic [RB+1:0] shf;
    logic [RB+1:0] trl;
    logic          ge;

    assign shf = {sq_rem_r[k-1][RB-1:0], sq_x_r[k-1][XB-2*k+1 -: 2]};
    assign trl = {sq_root_r[k-1], 2'b01};
    assign ge  = (shf >= trl);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[k] <= 1'b0;
      end else if (ce) begin
        sq_vld_r[k] <= sq_vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        sq_x_r[k]    <= sq_x_r[k-1];
        sq_rem_r[k]  <= ge ? (shf - trl) : shf;
        sq_root_r[k] <= {sq_root_r[k-1][RB-2:0], ge};
        sq_side_r[k] <= sq_side_r[k-1];
      end
    end
  end

  // Stage 13: numerators of both roots.
  logic                s13_vld_r;
  logic signed [W-1:0] s13_n1_r, s13_n2_r;
  sq_side_t            s13_side_r;
  logic signed [W-1:0] s13_sd;

  assign s13_sd = from_mag(1'b0, {{(MW-RB){1'b0}}, sq_root_r[RB]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s13_vld_r <= 1'b0;
    end else if (ce) begin
      s13_vld_r <= sq_vld_r[RB];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s13_n1_r   <= sat_w(ext(sq_side_r[RB].nqb) + ext(s13_sd));
      s13_n2_r   <= sat_w(ext(sq_side_r[RB].nqb) - ext(s13_sd));
      s13_side_r <= sq_side_r[RB];
    end
  end

  // Both roots divide by twice the quadratic term in parallel.
  d2_side_t                d2_side_in, d2_side_out;
  logic [D2_SIDE_BITS-1:0] d2_side_vec;
  logic                    d2_vld, d3_vld, d3_ok;
  logic signed [W-1:0]     d2_quo, d3_quo;

  assign d2_side_in  = '{ox: s13_side_r.ox, oy: s13_side_r.oy, aox: s13_side_r.aox,
                         aoy: s13_side_r.aoy, ok: s13_side_r.ok};
  assign d2_side_out = d2_side_t'(d2_side_vec);

  tcp_div #(
    .WORD_BITS     (W),
    .FRACTION_BITS (F),
    .SIDE_BITS     (D2_SIDE_BITS)
  ) u_div_root_one (
    .clk      (clk),
    .rst_n    (rst_n),
    .ce       (ce),
    .in_vld   (s13_vld_r),
    .num      (s13_n1_r),
    .den      (s13_side_r.twoa),
    .in_side  (d2_side_in),
    .out_vld  (d2_vld),
    .quo      (d2_quo),
    .out_side (d2_side_vec)
  );

  tcp_div #(
    .WORD_BITS     (W),
    .FRACTION_BITS (F),
    .SIDE_BITS     (1)
  ) u_div_root_two (
    .clk      (clk),
    .rst_n    (rst_n),
    .ce       (ce),
    .in_vld   (s13_vld_r),
    .num      (s13_n2_r),
    .den      (s13_side_r.twoa),
    .in_side  (s13_side_r.ok),
    .out_vld  (d3_vld),
    .quo      (d3_quo),
    .out_side (d3_ok)
  );

  // Stage 14: scale the normal by both roots.
  logic                  s14_vld_r;
  logic signed [2*W-1:0] s14_p1x_r, s14_p1y_r, s14_p2x_r, s14_p2y_r;
  logic signed [W-1:0]   s14_ox_r, s14_oy_r;
  logic                  s14_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s14_vld_r <= 1'b0;
    end else if (ce) begin
      s14_vld_r <= d2_vld && d3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s14_p1x_r <= mul(d2_quo, d2_side_out.aox);
      s14_p1y_r <= mul(d2_quo, d2_side_out.aoy);
      s14_p2x_r <= mul(d3_quo, d2_side_out.aox);
      s14_p2y_r <= mul(d3_quo, d2_side_out.aoy);
      s14_ox_r  <= d2_side_out.ox;
      s14_oy_r  <= d2_side_out.oy;
      s14_ok_r  <= d2_side_out.ok && d3_ok;
    end
  end

  // Output register: centres, or zeros with a count of none.
  count_t              out_cnt_r;
  logic signed [W-1:0] out_x1_r, out_y1_r, out_x2_r, out_y2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (ce) begin
      out_vld_r <= s14_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_cnt_r <= s14_ok_r ? SOL_PAIR : SOL_NONE;
      out_x1_r  <= s14_ok_r ? sat_w(ext(s14_ox_r) + ext(q_round(s14_p1x_r))) : '0;
      out_y1_r  <= s14_ok_r ? sat_w(ext(s14_oy_r) + ext(q_round(s14_p1y_r))) : '0;
      out_x2_r  <= s14_ok_r ? sat_w(ext(s14_ox_r) + ext(q_round(s14_p2x_r))) : '0;
      out_y2_r  <= s14_ok_r ? sat_w(ext(s14_oy_r) + ext(q_round(s14_p2y_r))) : '0;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.solution_count = out_cnt_r;
  assign out_ch.sol_one_x      = out_x1_r;
  assign out_ch.sol_one_y      = out_y1_r;
  assign out_ch.sol_two_x      = out_x2_r;
  assign out_ch.sol_two_y      = out_y2_r;

  // ---------------------------------------------------------------------
  // Checks.

  // The line divide never sees a zero divisor unless the centres coincide.
  `TCP_ASSERT_IMP(a_line_den_nonzero, s5_vld_r && !s5_zero_r, s5_den_r != '0)

  // A solvable item always reaches the root divides with a nonzero divisor.
  `TCP_ASSERT_IMP(a_root_den_nonzero, sq_vld_r[0] && sq_side_r[0].ok, sq_side_r[0].twoa != '0)

  // An item without solutions leaves all centres at zero.
  `TCP_ASSERT_IMP(a_none_zeroed, out_vld_r && (out_cnt_r == SOL_NONE),
                  (out_x1_r == '0) && (out_y1_r == '0) && (out_x2_r == '0) && (out_y2_r == '0))

  // Only the two defined counts are ever produced.
  `TCP_ASSERT_NEVER(a_count_code, out_vld_r && (out_cnt_r != SOL_NONE) && (out_cnt_r != SOL_PAIR))

endmodule
